@@ rtl/msd_pkg.sv @@
// Shared types, constants and helper functions of the mean squared displacement unit.
package msd_pkg;

  localparam int POS_W     = 32;
  localparam int SUM_W     = 63;
  localparam int MAX_ATOMS = 65536;
  localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
  localparam int IMG_BITS  = 10;
  localparam int IMG_W     = IMG_BITS + 1;
  localparam int FLAGS_W   = 30;
  localparam int PROD_W    = IMG_W + POS_W + 1;
  localparam int DISP_W    = PROD_W + 4;
  localparam int SQ_W      = 2 * POS_W - 16;
  localparam int SQT_W     = SQ_W + 2;
  localparam int REM_W     = CNT_W + 1;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 3;
  localparam int LANES     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRICLINIC = 3'd0,
    CFG_CENTER    = 3'd1,
    CFG_BOX_X     = 3'd2,
    CFG_BOX_Y     = 3'd3,
    CFG_BOX_Z     = 3'd4,
    CFG_TILT_YZ   = 3'd5,
    CFG_TILT_XZ   = 3'd6,
    CFG_TILT_XY   = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DISP, ST_SQR, ST_ACC, ST_DSTART, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic disp;
    logic sqr;
    logic acc;
    logic div_start;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic last;
    logic empty;
  } status_t;

  // Saturating accumulate: the sum sticks at its largest value.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SQT_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // Clamp a wide displacement to the signed Q16.16 range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [DISP_W-1:0] d);
    logic signed [POS_W-1:0] r;
    if (d[DISP_W-1:POS_W-1] == '0 || d[DISP_W-1:POS_W-1] == '1) begin
      r = d[POS_W-1:0];
    end else if (d[DISP_W-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/mean_squared_displacement_unit.sv @@
// Top level of the mean squared displacement unit: controller and datapath.
//
// One atom is transferred per input item (in_valid high, in_stall low). The
// unit unwraps the position through the box, subtracts the centre of mass when
// enabled and the original position, squares the clamped displacements and
// adds them to saturating 63-bit frame sums.
// An in-group atom passes through the controller's multiply, displacement,
// square and accumulate registers before the next item can be taken; an atom
// that is not counted is done after the multiply register. On an item marked
// last_atom the sums go through a restoring divider that produces one quotient
// bit per cycle, all four means together, before the result is offered on
// out_valid; an empty group skips the divider. in_stall stays high from a
// transfer until the unit is ready again, including while a result waits.
// While the receiver holds out_stall high the result holds steady.
// Synchronous active-low reset clears the sums, the count and the controller
// and loads the configuration defaults. The configuration port is always
// ready; it should be written only while the unit is idle.
module mean_squared_displacement_unit import msd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [POS_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic [FLAGS_W-1:0]      in_image_flags,
  input  logic signed [POS_W-1:0] in_orig_x,
  input  logic signed [POS_W-1:0] in_orig_y,
  input  logic signed [POS_W-1:0] in_orig_z,
  input  logic signed [POS_W-1:0] in_center_x,
  input  logic signed [POS_W-1:0] in_center_y,
  input  logic signed [POS_W-1:0] in_center_z,
  input  logic                    in_in_group,
  input  logic                    in_last_atom,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SUM_W-1:0]        out_msd_x,
  output logic [SUM_W-1:0]        out_msd_y,
  output logic [SUM_W-1:0]        out_msd_z,
  output logic [SUM_W-1:0]        out_msd_total,
  output logic                    out_group_empty
);

  cmd_t    cmd;
  status_t status;

  // Register writes are taken whenever they are offered, so the port never pushes back.
  assign cfg_ready = 1'b1;

  msd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  msd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_image_flags  (in_image_flags),
    .in_orig_x       (in_orig_x),
    .in_orig_y       (in_orig_y),
    .in_orig_z       (in_orig_z),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_center_z     (in_center_z),
    .in_in_group     (in_in_group),
    .in_last_atom    (in_last_atom),
    .cmd             (cmd),
    .status          (status),
    .out_msd_x       (out_msd_x),
    .out_msd_y       (out_msd_y),
    .out_msd_z       (out_msd_z),
    .out_msd_total   (out_msd_total),
    .out_group_empty (out_group_empty)
  );

endmodule

@@ rtl/msd_ctrl.sv @@
// Sequencing state machine of the mean squared displacement unit.
module msd_ctrl import msd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (status.take) begin
          state_nxt = ST_DISP;
        end else if (status.last) begin
          state_nxt = ST_DSTART;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DISP: begin
        cmd.disp  = 1'b1;
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = status.last ? ST_DSTART : ST_IDLE;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        step_nxt      = '0;
        state_nxt     = status.empty ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/msd_dp.sv @@
// Datapath: configuration registers, unwrap, squares, sums and the shared divider.
module msd_dp import msd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [POS_W-1:0]            cfg_data,
  input  logic signed [POS_W-1:0]     in_pos_x,
  input  logic signed [POS_W-1:0]     in_pos_y,
  input  logic signed [POS_W-1:0]     in_pos_z,
  input  logic [FLAGS_W-1:0]          in_image_flags,
  input  logic signed [POS_W-1:0]     in_orig_x,
  input  logic signed [POS_W-1:0]     in_orig_y,
  input  logic signed [POS_W-1:0]     in_orig_z,
  input  logic signed [POS_W-1:0]     in_center_x,
  input  logic signed [POS_W-1:0]     in_center_y,
  input  logic signed [POS_W-1:0]     in_center_z,
  input  logic                        in_in_group,
  input  logic                        in_last_atom,
  input  cmd_t                        cmd,
  output status_t                     status,
  output logic [SUM_W-1:0]            out_msd_x,
  output logic [SUM_W-1:0]            out_msd_y,
  output logic [SUM_W-1:0]            out_msd_z,
  output logic [SUM_W-1:0]            out_msd_total,
  output logic                        out_group_empty
);

  // Configuration.
  logic                    tric_r, cen_en_r;
  logic [POS_W-1:0]        box_x_r, box_y_r, box_z_r;
  logic signed [POS_W-1:0] tyz_r, txz_r, txy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tric_r   <= 1'b0;
      cen_en_r <= 1'b0;
      box_x_r  <= POS_W'(65536);
      box_y_r  <= POS_W'(65536);
      box_z_r  <= POS_W'(65536);
      tyz_r    <= '0;
      txz_r    <= '0;
      txy_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TRICLINIC: tric_r   <= cfg_data[0];
        CFG_CENTER:    cen_en_r <= cfg_data[0];
        CFG_BOX_X:     box_x_r  <= cfg_data;
        CFG_BOX_Y:     box_y_r  <= cfg_data;
        CFG_BOX_Z:     box_z_r  <= cfg_data;
        CFG_TILT_YZ:   tyz_r    <= cfg_data;
        CFG_TILT_XZ:   txz_r    <= cfg_data;
        CFG_TILT_XY:   txy_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured item.
  logic signed [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [POS_W-1:0] rel_x_r, rel_y_r, rel_z_r;
  logic [FLAGS_W-1:0]      img_r;
  logic                    grp_r, last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      rel_x_r <= in_orig_x;
      rel_y_r <= in_orig_y;
      rel_z_r <= in_orig_z;
      img_r   <= in_image_flags;
      grp_r   <= in_in_group;
      last_r  <= in_last_atom;
    end
  end

  // Centre of mass, taken with the item.
  logic signed [POS_W-1:0] cx_r, cy_r, cz_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= in_center_x;
      cy_r <= in_center_y;
      cz_r <= in_center_z;
    end
  end

  // Image counts, offset by half the code range.
  logic signed [IMG_W-1:0] xb, yb, zb;
  assign xb = $signed({1'b0, img_r[IMG_BITS-1:0]}) - IMG_W'(1 << (IMG_BITS - 1));
  assign yb = $signed({1'b0, img_r[2*IMG_BITS-1:IMG_BITS]}) - IMG_W'(1 << (IMG_BITS - 1));
  assign zb = $signed({1'b0, img_r[3*IMG_BITS-1:2*IMG_BITS]})
              - IMG_W'(1 << (IMG_BITS - 1));

  logic signed [PROD_W-1:0] pbx_r, pby_r, pbz_r, ptxy_r, ptxz_r, ptyz_r;
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pbx_r  <= xb * $signed({1'b0, box_x_r});
      pby_r  <= yb * $signed({1'b0, box_y_r});
      pbz_r  <= zb * $signed({1'b0, box_z_r});
      ptxy_r <= tric_r ? PROD_W'(yb * txy_r) : '0;
      ptxz_r <= tric_r ? PROD_W'(zb * txz_r) : '0;
      ptyz_r <= tric_r ? PROD_W'(zb * tyz_r) : '0;
    end
  end

  logic signed [DISP_W-1:0] dxw, dyw, dzw;
  logic signed [POS_W-1:0]  cxe, cye, cze;
  assign cxe = cen_en_r ? cx_r : '0;
  assign cye = cen_en_r ? cy_r : '0;
  assign cze = cen_en_r ? cz_r : '0;
  assign dxw = DISP_W'(pos_x_r) + DISP_W'(pbx_r) + DISP_W'(ptxy_r) + DISP_W'(ptxz_r)
               - DISP_W'(cxe) - DISP_W'(rel_x_r);
  assign dyw = DISP_W'(pos_y_r) + DISP_W'(pby_r) + DISP_W'(ptyz_r)
               - DISP_W'(cye) - DISP_W'(rel_y_r);
  assign dzw = DISP_W'(pos_z_r) + DISP_W'(pbz_r) - DISP_W'(cze) - DISP_W'(rel_z_r);

  logic signed [POS_W-1:0] dx_r, dy_r, dz_r;
  always_ff @(posedge clk) begin
    if (cmd.disp) begin
      dx_r <= sat_pos(dxw);
      dy_r <= sat_pos(dyw);
      dz_r <= sat_pos(dzw);
    end
  end

  logic signed [2*POS_W-1:0] sqx, sqy, sqz;
  assign sqx = dx_r * dx_r;
  assign sqy = dy_r * dy_r;
  assign sqz = dz_r * dz_r;

  logic [SQ_W-1:0] qx_r, qy_r, qz_r;
  always_ff @(posedge clk) begin
    if (cmd.sqr) begin
      qx_r <= sqx[2*POS_W-1:16];
      qy_r <= sqy[2*POS_W-1:16];
      qz_r <= sqz[2*POS_W-1:16];
    end
  end

  logic [SQT_W-1:0] qt;
  assign qt = SQT_W'(qx_r) + SQT_W'(qy_r) + SQT_W'(qz_r);

  // Frame sums and atom count.
  logic [SUM_W-1:0] sx_r, sy_r, sz_r, st_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.div_start) begin
      sx_r  <= '0;
      sy_r  <= '0;
      sz_r  <= '0;
      st_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.acc) begin
      sx_r  <= sat_add(sx_r, SQT_W'(qx_r));
      sy_r  <= sat_add(sy_r, SQT_W'(qy_r));
      sz_r  <= sat_add(sz_r, SQT_W'(qz_r));
      st_r  <= sat_add(st_r, qt);
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign status.take  = grp_r && (cnt_r < CNT_W'(MAX_ATOMS));
  assign status.last  = last_r;
  assign status.empty = (cnt_r == '0);

  // Restoring divider, four lanes sharing one divisor, one quotient bit a step.
  logic [SUM_W-1:0] dvd_r [LANES];
  logic [CNT_W-1:0] rem_r [LANES];
  logic [CNT_W-1:0] dvs_r;
  logic             empty_r;
  logic [REM_W-1:0] rsh   [LANES];
  logic             qbit  [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rsh[i]  = {rem_r[i], dvd_r[i][SUM_W-1]};
      qbit[i] = (rsh[i] >= REM_W'(dvs_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvs_r    <= cnt_r;
      empty_r  <= (cnt_r == '0);
      dvd_r[0] <= sx_r;
      dvd_r[1] <= sy_r;
      dvd_r[2] <= sz_r;
      dvd_r[3] <= st_r;
      for (int i = 0; i < LANES; i++) begin
        rem_r[i] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < LANES; i++) begin
        rem_r[i] <= qbit[i] ? CNT_W'(rsh[i] - REM_W'(dvs_r)) : CNT_W'(rsh[i]);
        dvd_r[i] <= {dvd_r[i][SUM_W-2:0], qbit[i]};
      end
    end
  end

  assign out_msd_x       = dvd_r[0];
  assign out_msd_y       = dvd_r[1];
  assign out_msd_z       = dvd_r[2];
  assign out_msd_total   = dvd_r[3];
  assign out_group_empty = empty_r;

endmodule

@@ rtl/msd_checker.sv @@
// Port-level checker of the mean squared displacement unit and its bind.
module msd_port_props import msd_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [SUM_W-1:0] out_msd_x,
  input logic [SUM_W-1:0] out_msd_total,
  input logic             out_group_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_msd_total))
    else $error("result dropped or changed while stalled");

  a_no_take_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_group_empty |-> out_msd_x == '0 && out_msd_total == '0)
    else $error("empty group with non-zero means");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_msd_x <= out_msd_total)
    else $error("x mean exceeds total mean");

endmodule

bind mean_squared_displacement_unit msd_port_props u_msd_port_props (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_msd_x       (out_msd_x),
  .out_msd_total   (out_msd_total),
  .out_group_empty (out_group_empty)
);
